>>> rtl/swpw_pkg.sv
// Shared types and constants for the single-wire pulse-width transactor.
package swpw_pkg;

    localparam int LINE_COUNT_DEF = 4;
    localparam int DATA_BITS_DEF  = 8;
    localparam int PHASE_W        = 5;
    localparam int BYTE_W         = 8;

    // long symbols hold for four ticks, rest adds three high ticks
    localparam logic [1:0] LONG_MAX = 2'd3;
    localparam logic [1:0] REST_MAX = 2'd2;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [1:0] {
        OP_DATA_WR = 2'd0,
        OP_DATA_RD = 2'd1,
        OP_ADDR_WR = 2'd2,
        OP_ADDR_RD = 2'd3
    } t_op;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 5'd0,
        PH_PRE    = 5'd1,
        PH_START1 = 5'd2,
        PH_START2 = 5'd3,
        PH_ADDR   = 5'd4,
        PH_SLOW   = 5'd5,
        PH_OP1    = 5'd6,
        PH_OP0    = 5'd7,
        PH_INCR   = 5'd8,
        PH_WDATA  = 5'd9,
        PH_END    = 5'd10,
        PH_RLOW   = 5'd11,
        PH_RREL   = 5'd12,
        PH_RWAIT  = 5'd13,
        PH_RSAMP  = 5'd14,
        PH_RSTORE = 5'd15,
        PH_RREST  = 5'd16
    } t_phase;

    typedef struct packed {
        logic       req_type;
        logic [1:0] bus_index;
        logic [1:0] op_code;
        logic [7:0] write_byte;
        logic       line_sample;
    } t_req;

    typedef struct packed {
        logic       line_level;
        logic       line_drive;
        logic [1:0] line_select;
        logic       accepted;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } t_res;

endpackage

>>> rtl/swpw_if.sv
// Request and result channel interfaces (valid/ready with payload).
interface swpw_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [1:0] bus_index;
    logic [1:0] op_code;
    logic [7:0] write_byte;
    logic       line_sample;

    modport source (output valid, req_type, bus_index, op_code, write_byte, line_sample,
                    input ready);
    modport sink   (input valid, req_type, bus_index, op_code, write_byte, line_sample,
                    output ready);
endinterface

interface swpw_res_if;
    logic       valid;
    logic       ready;
    logic       line_level;
    logic       line_drive;
    logic [1:0] line_select;
    logic       accepted;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;

    modport source (output valid, line_level, line_drive, line_select, accepted, busy_res,
                    done_res, read_byte, input ready);
    modport sink   (input valid, line_level, line_drive, line_select, accepted, busy_res,
                    done_res, read_byte, output ready);
endinterface

>>> rtl/swpw_in_stage.sv
// Input register for incoming requests.
module swpw_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    swpw_req_if.sink        i_req,
    input  logic            i_take,
    output logic            o_valid,
    output swpw_pkg::t_req  o_req
);
    import swpw_pkg::*;

    logic r_valid;
    t_req r_req;

    assign i_req.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_req       = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.req_type    <= i_req.req_type;
            r_req.bus_index   <= i_req.bus_index;
            r_req.op_code     <= i_req.op_code;
            r_req.write_byte  <= i_req.write_byte;
            r_req.line_sample <= i_req.line_sample;
        end
    end
endmodule

>>> rtl/swpw_engine.sv
// Frame sequencer: bus state and next-state/result logic for one request.
module swpw_engine #(
    parameter int LINE_COUNT = swpw_pkg::LINE_COUNT_DEF,
    parameter int DATA_BITS  = swpw_pkg::DATA_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  swpw_pkg::t_req  i_req,
    output swpw_pkg::t_res  o_res
);
    import swpw_pkg::*;

    localparam int BP_W = $clog2(DATA_BITS + 1);
    localparam int EXT_W = (DATA_BITS > BYTE_W) ? DATA_BITS : BYTE_W;

    t_phase                r_phase, n_phase;
    logic                  r_half, n_half;
    logic [1:0]            r_lsc, n_lsc;
    logic [1:0]            r_rest, n_rest;
    logic [BP_W-1:0]       r_bitpos, n_bitpos;
    logic [DATA_BITS-1:0]  r_shift, n_shift;
    logic [1:0]            r_op, n_op;
    logic [1:0]            r_line, n_line;
    logic                  r_samp, n_samp;
    logic                  r_level, n_level;
    logic                  r_drive, n_drive;

    logic                  w_rd;
    logic                  w_samp;
    logic                  w_one;
    logic                  w_wbit;
    t_phase                w_hdr_next;
    t_phase                w_after_bit;
    logic [BP_W-1:0]       w_bitpos_inc;
    logic [DATA_BITS-1:0]  w_shifted;
    logic [DATA_BITS-1:0]  w_mask;
    logic [EXT_W-1:0]      w_wb_ext;
    logic [EXT_W-1:0]      w_sh_ext;

    assign w_rd         = r_op[0];
    assign w_samp       = (r_phase == PH_RSAMP && r_half) ? i_req.line_sample : r_samp;
    assign w_one        = ((r_phase == PH_OP1) && r_op[1]) || ((r_phase == PH_OP0) && r_op[0]);
    assign w_shifted    = r_shift >> r_bitpos;
    assign w_wbit       = w_shifted[0];
    assign w_mask       = DATA_BITS'(1) << r_bitpos;
    assign w_bitpos_inc = r_bitpos + BP_W'(1);
    assign w_wb_ext     = EXT_W'(i_req.write_byte);
    assign w_sh_ext     = EXT_W'(r_shift);
    assign w_after_bit  = (r_bitpos < BP_W'(DATA_BITS)) ? PH_RLOW : PH_END;
    assign w_hdr_next   = (r_phase == PH_INCR) ? (w_rd ? PH_RLOW : PH_WDATA)
                                               : t_phase'(PHASE_W'(r_phase) + PHASE_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_half   <= 1'b0;
            r_lsc    <= '0;
            r_rest   <= '0;
            r_bitpos <= '0;
            r_shift  <= '0;
            r_op     <= '0;
            r_line   <= '0;
            r_samp   <= 1'b0;
            r_level  <= 1'b0;
            r_drive  <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_half   <= n_half;
            r_lsc    <= n_lsc;
            r_rest   <= n_rest;
            r_bitpos <= n_bitpos;
            r_shift  <= n_shift;
            r_op     <= n_op;
            r_line   <= n_line;
            r_samp   <= n_samp;
            r_level  <= n_level;
            r_drive  <= n_drive;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_half   = r_half;
        n_lsc    = r_lsc;
        n_rest   = r_rest;
        n_bitpos = r_bitpos;
        n_shift  = r_shift;
        n_op     = r_op;
        n_line   = r_line;
        n_samp   = r_samp;
        n_level  = r_level;
        n_drive  = r_drive;
        o_res.accepted  = 1'b0;
        o_res.done_res  = 1'b0;
        o_res.read_byte = '0;

        if (i_req.req_type == REQ_START) begin
            if (r_phase == PH_IDLE && 32'(i_req.bus_index) < 32'(LINE_COUNT)) begin
                o_res.accepted = 1'b1;
                n_line   = i_req.bus_index;
                n_op     = i_req.op_code;
                n_shift  = i_req.op_code[0] ? '0 : w_wb_ext[DATA_BITS-1:0];
                n_bitpos = '0;
                n_half   = 1'b0;
                n_lsc    = '0;
                n_rest   = '0;
                n_samp   = 1'b0;
                n_level  = 1'b1;
                n_drive  = 1'b1;
                n_phase  = PH_PRE;
            end
        end else if (r_phase != PH_IDLE) begin
            n_samp = w_samp;
            case (r_phase)
                PH_PRE: begin
                    n_phase = PH_START1;
                end
                PH_START1, PH_START2, PH_ADDR, PH_SLOW, PH_OP1, PH_OP0, PH_INCR: begin
                    // header levels alternate, starting high on an even phase code
                    n_level = ~r_phase[0];
                    n_drive = 1'b1;
                    if (w_one && r_lsc < LONG_MAX) begin
                        n_lsc = r_lsc + 2'd1;
                    end else begin
                        n_lsc = '0;
                        if (w_rd && !r_half) begin
                            n_half = 1'b1;
                        end else begin
                            n_half  = 1'b0;
                            n_phase = w_hdr_next;
                        end
                    end
                end
                PH_WDATA: begin
                    n_level = r_bitpos[0];
                    n_drive = 1'b1;
                    if (w_wbit && r_lsc < LONG_MAX) begin
                        n_lsc = r_lsc + 2'd1;
                    end else begin
                        n_lsc    = '0;
                        n_bitpos = w_bitpos_inc;
                        if (w_bitpos_inc >= BP_W'(DATA_BITS)) begin
                            n_phase = PH_END;
                        end
                    end
                end
                PH_END: begin
                    n_level = 1'b0;
                    n_drive = 1'b1;
                    n_phase = PH_IDLE;
                    o_res.done_res  = 1'b1;
                    o_res.read_byte = w_rd ? w_sh_ext[BYTE_W-1:0] : '0;
                end
                PH_RLOW: begin
                    n_half = ~r_half;
                    if (!r_half) begin
                        n_level = 1'b0;
                        n_drive = 1'b1;
                    end else begin
                        n_phase = PH_RREL;
                    end
                end
                PH_RREL: begin
                    n_half = ~r_half;
                    if (!r_half) begin
                        n_level = 1'b0;
                        n_drive = 1'b0;
                    end else begin
                        n_phase = PH_RWAIT;
                    end
                end
                PH_RWAIT: begin
                    n_half = ~r_half;
                    if (r_half) begin
                        n_phase = PH_RSAMP;
                    end
                end
                PH_RSAMP: begin
                    n_half = ~r_half;
                    if (r_half) begin
                        // echo the level just sampled
                        n_level = w_samp;
                        n_drive = 1'b1;
                        n_phase = PH_RSTORE;
                    end
                end
                PH_RSTORE: begin
                    n_half = ~r_half;
                    if (!r_half) begin
                        n_shift  = w_samp ? (r_shift | w_mask) : (r_shift & ~w_mask);
                        n_bitpos = w_bitpos_inc;
                    end else if (!w_samp) begin
                        n_phase = PH_RREST;
                    end else begin
                        n_phase = w_after_bit;
                    end
                end
                PH_RREST: begin
                    n_level = 1'b1;
                    n_drive = 1'b1;
                    if (r_rest < REST_MAX) begin
                        n_rest = r_rest + 2'd1;
                    end else begin
                        n_rest  = '0;
                        n_phase = w_after_bit;
                    end
                end
                default: begin
                end
            endcase
        end

        o_res.line_level  = n_drive & n_level;
        o_res.line_drive  = n_drive;
        o_res.line_select = n_line;
        o_res.busy_res    = (n_phase != PH_IDLE);
    end
endmodule

>>> rtl/swpw_out_stage.sv
// Result register driving the result channel.
module swpw_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  swpw_pkg::t_res  i_res,
    output logic            o_can_load,
    swpw_res_if.source      o_res
);
    import swpw_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.line_level  = r_res.line_level;
    assign o_res.line_drive  = r_res.line_drive;
    assign o_res.line_select = r_res.line_select;
    assign o_res.accepted    = r_res.accepted;
    assign o_res.busy_res    = r_res.busy_res;
    assign o_res.done_res    = r_res.done_res;
    assign o_res.read_byte   = r_res.read_byte;
endmodule

>>> rtl/single_wire_pulse_width_transactor_core.sv
// Tick-driven single-wire pulse-width bus master: one result per request, one request per
// clock while the result channel is not stalled. A request is registered on entry, the frame
// sequencer computes the new bus state and result in one pass, and the result is registered
// on exit; the request register can hold the next request while a result waits to be taken.
// Start requests accepted while idle load the operation and drive the chosen wire high; each
// tick request advances the frame (header symbols, opcode bits, increment symbol, then the
// data bits of a write or the sampled bits of a read) and the final tick reports done, with
// the assembled byte on reads.
module single_wire_pulse_width_transactor_core #(
    parameter int LINE_COUNT = swpw_pkg::LINE_COUNT_DEF,
    parameter int DATA_BITS  = swpw_pkg::DATA_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swpw_req_if.sink    i_req,
    swpw_res_if.source  o_res
);
    import swpw_pkg::*;

    logic w_in_valid;
    t_req w_req;
    t_res w_res;
    logic w_can_load;
    logic w_fire;

    assign w_fire = w_in_valid && w_can_load;

    swpw_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_req   (w_req)
    );

    swpw_engine #(
        .LINE_COUNT (LINE_COUNT),
        .DATA_BITS  (DATA_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    swpw_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_res      (o_res)
    );
endmodule

>>> rtl/swpw_chk.sv
// Port-level checks for the transactor core, bound to the top level.
module swpw_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_line_level,
    input logic       i_line_drive,
    input logic       i_accepted,
    input logic       i_busy,
    input logic       i_done,
    input logic [7:0] i_read_byte
);
    // a frame always ends with the wire driven low and the bus free
    a_done_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_done |-> i_line_drive && !i_line_level && !i_busy)
        else $error("done without wire low and bus idle");

    // a taken start drives the wire high and marks the bus busy
    a_start_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_accepted |-> i_line_drive && i_line_level && i_busy)
        else $error("accepted start without wire high and busy");

    a_byte_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_done |-> i_read_byte == 8'd0)
        else $error("read byte shown outside done");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_done) && $stable(i_read_byte))
        else $error("stalled result changed");
endmodule

bind single_wire_pulse_width_transactor_core swpw_chk u_swpw_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_line_level (o_res.line_level),
    .i_line_drive (o_res.line_drive),
    .i_accepted   (o_res.accepted),
    .i_busy       (o_res.busy_res),
    .i_done       (o_res.done_res),
    .i_read_byte  (o_res.read_byte)
);

>>> verif/single_wire_pulse_width_transactor_core_tb.sv
// Self-checking bench for the pulse-width transactor core: directed table, then random frames.
`timescale 1ns / 100ps

module single_wire_pulse_width_transactor_core_tb;
    import swpw_pkg::*;

    localparam int ITEM_TARGET    = 1500;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int DIR_ROWS       = 6;

    typedef struct {
        t_req req;
        int   reps;
        bit   typed;
        t_res want;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    swpw_req_if req_ch ();
    swpw_res_if res_ch ();

    single_wire_pulse_width_transactor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // frame sequencer state, mirrored from the block's behavior
    t_phase      fr_phase  = PH_IDLE;
    logic        fr_half   = 1'b0;
    logic [1:0]  fr_long   = '0;
    logic [1:0]  fr_rest   = '0;
    logic [3:0]  fr_bit    = '0;
    logic [7:0]  fr_shift  = '0;
    logic [1:0]  fr_op     = '0;
    logic [1:0]  fr_line   = '0;
    logic        fr_sample = 1'b0;
    logic        wire_lvl  = 1'b0;
    logic        wire_drv  = 1'b0;

    t_res        expected_bus_q[$];
    t_dir_row    dir_rows[DIR_ROWS];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          frames_sent    = 0;
    int          op_frames[4]   = '{0, 0, 0, 0};
    int          idle_cycles    = 0;
    int          stall_left     = 0;
    logic        quiet          = 1'b0;

    function automatic void drive_wire(input logic lvl);
        wire_lvl = lvl;
        wire_drv = 1'b1;
    endfunction

    function automatic t_phase next_bit_phase();
        return (fr_bit < DATA_BITS_DEF) ? PH_RLOW : PH_END;
    endfunction

    // one tick of a header symbol; reads stretch every step over two ticks
    function automatic void bus_symbol_step(input logic lvl, input logic one,
                                            input t_phase nxt);
        drive_wire(lvl);
        if (one && fr_long < LONG_MAX) begin
            fr_long++;
            return;
        end
        fr_long = '0;
        if (fr_op[0] && !fr_half) begin
            fr_half = 1'b1;
            return;
        end
        fr_half  = 1'b0;
        fr_phase = nxt;
    endfunction

    function automatic bit frame_tick();
        logic       h;
        logic [4:0] k;
        logic       one;
        h = fr_half;
        frame_tick = 1'b0;
        case (fr_phase)
            PH_IDLE: ;
            PH_PRE: fr_phase = PH_START1;
            PH_INCR: bus_symbol_step(1'b1, 1'b0, fr_op[0] ? PH_RLOW : PH_WDATA);
            PH_WDATA: begin
                drive_wire(fr_bit[0]);
                if (fr_shift[fr_bit[2:0]] && fr_long < LONG_MAX) begin
                    fr_long++;
                end else begin
                    fr_long = '0;
                    fr_bit++;
                    if (fr_bit >= DATA_BITS_DEF) fr_phase = PH_END;
                end
            end
            PH_END: begin
                drive_wire(1'b0);
                fr_phase   = PH_IDLE;
                frame_tick = 1'b1;
            end
            PH_RLOW, PH_RREL, PH_RWAIT, PH_RSAMP, PH_RSTORE: begin
                fr_half = ~h;
                case (fr_phase)
                    PH_RLOW: begin
                        if (!h) drive_wire(1'b0);
                        else fr_phase = PH_RREL;
                    end
                    PH_RREL: begin
                        if (!h) begin
                            wire_drv = 1'b0;
                            wire_lvl = 1'b0;
                        end else begin
                            fr_phase = PH_RWAIT;
                        end
                    end
                    PH_RWAIT: if (h) fr_phase = PH_RSAMP;
                    PH_RSAMP: begin
                        if (h) begin
                            drive_wire(fr_sample);
                            fr_phase = PH_RSTORE;
                        end
                    end
                    default: begin
                        if (!h) begin
                            fr_shift[fr_bit[2:0]] = fr_sample;
                            fr_bit++;
                        end else if (!fr_sample) begin
                            fr_phase = PH_RREST;
                        end else begin
                            fr_phase = next_bit_phase();
                        end
                    end
                endcase
            end
            PH_RREST: begin
                drive_wire(1'b1);
                if (fr_rest < REST_MAX) begin
                    fr_rest++;
                end else begin
                    fr_rest  = '0;
                    fr_phase = next_bit_phase();
                end
            end
            default: begin
                // header: start, start, address-follow, slow-access, opcode bits
                k   = 5'(fr_phase - PH_START1);
                one = (fr_phase == PH_OP1) ? fr_op[1] :
                      (fr_phase == PH_OP0) ? fr_op[0] : 1'b0;
                bus_symbol_step(~k[0], one, t_phase'(fr_phase + 5'd1));
            end
        endcase
    endfunction

    function automatic t_res predict_bus_result(input t_req r);
        t_res res;
        res = '0;
        if (r.req_type == REQ_START) begin
            if (fr_phase == PH_IDLE && int'(r.bus_index) < LINE_COUNT_DEF) begin
                res.accepted = 1'b1;
                fr_line   = r.bus_index;
                fr_op     = r.op_code;
                fr_shift  = fr_op[0] ? 8'h00 : r.write_byte;
                fr_bit    = '0;
                fr_half   = 1'b0;
                fr_long   = '0;
                fr_rest   = '0;
                fr_sample = 1'b0;
                drive_wire(1'b1);
                fr_phase  = PH_PRE;
            end
        end else if (fr_phase != PH_IDLE) begin
            if (fr_phase == PH_RSAMP && fr_half) fr_sample = r.line_sample;
            if (frame_tick()) begin
                res.done_res = 1'b1;
                if (fr_op[0]) res.read_byte = fr_shift;
            end
        end
        res.line_level  = wire_drv & wire_lvl;
        res.line_drive  = wire_drv;
        res.line_select = fr_line;
        res.busy_res    = (fr_phase != PH_IDLE);
        return res;
    endfunction

    // mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 1) == 0) return 0;
        return idle_len();
    endfunction

    task automatic send_req(input t_req r, input int gap, input bit typed,
                            input t_res typed_res);
        t_res pred;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.req_type;
        req_ch.bus_index   <= r.bus_index;
        req_ch.op_code     <= r.op_code;
        req_ch.write_byte  <= r.write_byte;
        req_ch.line_sample <= r.line_sample;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        pred = predict_bus_result(r);
        expected_bus_q.push_back(typed ? typed_res : pred);
    endtask

    // tick with random filler in the fields the block ignores on ticks
    task automatic send_tick(input logic line_bit);
        t_req r;
        r = '{REQ_TICK, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), line_bit};
        send_req(r, pick_gap(), 1'b0, '0);
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_res got;
        t_res want;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got = '{res_ch.line_level, res_ch.line_drive, res_ch.line_select,
                    res_ch.accepted, res_ch.busy_res, res_ch.done_res, res_ch.read_byte};
            if (expected_bus_q.size() == 0) begin
                $display("%0t: result with no request pending: actual 0x%0h", $time, got);
                mismatch_count++;
            end else begin
                want = expected_bus_q.pop_front();
                compare_field("line_level", 8'(want.line_level), 8'(got.line_level));
                compare_field("line_drive", 8'(want.line_drive), 8'(got.line_drive));
                compare_field("line_select", 8'(want.line_select), 8'(got.line_select));
                compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
                compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
                compare_field("read_byte", want.read_byte, got.read_byte);
            end
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        if (stall_left != 0 && !quiet) begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            stall_left   <= (!quiet && $urandom_range(0, 9) < 3) ? idle_len() : 0;
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_op        op;
        logic [7:0] wr_data;
        int         line_mode;
        int         fidx;
        logic       line_bit;
        t_req       r;

        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_TICK;
        req_ch.bus_index   <= '0;
        req_ch.op_code     <= '0;
        req_ch.write_byte  <= '0;
        req_ch.line_sample <= 1'b0;
        res_ch.ready       =  1'b0;

        // short data write of 0x00 on the top wire, with idle ticks and a refused start: every symbol is one tick
        dir_rows = '{
            '{'{REQ_TICK, 2'd0, 2'd0, 8'h00, 1'b1}, 1, 1'b1,
              '{1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00}},
            '{'{REQ_START, 2'd3, OP_DATA_WR, 8'h00, 1'b0}, 1, 1'b1,
              '{1'b1, 1'b1, 2'd3, 1'b1, 1'b1, 1'b0, 8'h00}},
            '{'{REQ_START, 2'd0, OP_ADDR_RD, 8'hFF, 1'b1}, 1, 1'b1,
              '{1'b1, 1'b1, 2'd3, 1'b0, 1'b1, 1'b0, 8'h00}},
            '{'{REQ_TICK, 2'd1, 2'd1, 8'hFF, 1'b1}, 16, 1'b0, '0},
            '{'{REQ_TICK, 2'd2, 2'd2, 8'hA5, 1'b0}, 1, 1'b1,
              '{1'b0, 1'b1, 2'd3, 1'b0, 1'b0, 1'b1, 8'h00}},
            '{'{REQ_TICK, 2'd0, 2'd3, 8'h5A, 1'b1}, 1, 1'b1,
              '{1'b0, 1'b1, 2'd3, 1'b0, 1'b0, 1'b0, 8'h00}}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            for (int n = 0; n < dir_rows[i].reps; n++) begin
                send_req(dir_rows[i].req, pick_gap(), dir_rows[i].typed, dir_rows[i].want);
                items_sent++;
            end
        end

        fidx = 0;
        while (items_sent < ITEM_TARGET) begin
            op        = (fidx < 4) ? t_op'(fidx) : t_op'($urandom_range(0, 3));
            wr_data   = (fidx == 0) ? 8'hFF : 8'($urandom_range(0, 255));
            // read frames: all ones, all zeros (every bit takes the rest), or mixed
            line_mode = (fidx == 1) ? 1 : (fidx == 3) ? 2 :
                        ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
            quiet    <= (fidx % 6 == 2);

            // stray ticks between frames are ignored by the block
            repeat ($urandom_range(0, 2)) begin
                send_tick(1'($urandom_range(0, 1)));
                items_sent++;
            end

            r = '{REQ_START, 2'($urandom_range(0, 3)), op, wr_data,
                  1'($urandom_range(0, 1))};
            send_req(r, pick_gap(), 1'b0, '0);
            items_sent++;
            frames_sent++;
            op_frames[op]++;

            while (fr_phase != PH_IDLE) begin
                if ($urandom_range(0, 19) == 0) begin
                    // start request while busy: must be refused
                    r = '{REQ_START, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))};
                    send_req(r, pick_gap(), 1'b0, '0);
                    items_sent++;
                end else begin
                    line_bit = (line_mode == 1) ? 1'b1 :
                               (line_mode == 2) ? 1'b0 : 1'($urandom_range(0, 1));
                    send_tick(line_bit);
                    items_sent++;
                end
            end

            if (fidx == 5) begin
                req_ch.valid <= 1'b0;
                while (expected_bus_q.size() != 0) @(posedge i_clk);
            end
            fidx++;
        end

        req_ch.valid <= 1'b0;
        while (expected_bus_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests in %0d random frames after the directed table", items_sent,
                 frames_sent);
        $display("Frames by op (data wr/rd, addr wr/rd): %0d/%0d/%0d/%0d, %0d mismatches",
                 op_frames[0], op_frames[1], op_frames[2], op_frames[3], mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> single_wire_pulse_width_transactor_core.f
rtl/swpw_pkg.sv
rtl/swpw_if.sv
rtl/swpw_in_stage.sv
rtl/swpw_engine.sv
rtl/swpw_out_stage.sv
rtl/single_wire_pulse_width_transactor_core.sv
rtl/swpw_chk.sv
verif/single_wire_pulse_width_transactor_core_tb.sv
